// ===== hw/rtl/frame_ring_buffer_overwrite_oldest_core_macros.svh =====
// Assertion macros shared by the frame ring buffer checkers.
`ifndef FRAME_RING_BUFFER_OVERWRITE_OLDEST_CORE_MACROS_SVH
`define FRAME_RING_BUFFER_OVERWRITE_OLDEST_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define FRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define FRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/frb_pkg.sv =====
// Shared codes and field widths of the frame ring buffer.
`default_nettype none

package frb_pkg;

  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_POPPED  = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_STORED  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_TRUNC   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_FLUSHED = 3'd5;

endpackage

`default_nettype wire

// ===== hw/rtl/frame_ring_buffer_overwrite_oldest_core.sv =====
// Top level of the frame ring buffer that overwrites the oldest frame when full.
//
//   Channel | Ports                                           | Direction
//   --------+-------------------------------------------------+----------
//   input   | in_valid in_ready in_kind in_data_byte          | in
//           | in_last_byte                                    |
//   result  | out_valid out_ready out_byte out_last           | out
//           | out_status out_frame_count                      |
//
// Each item passes through the transfer cycle, which issues the reads of the
// byte store and the length store, and the in-flight stage, which uses the read
// data, writes the stores and updates the indices. One item is in flight at a time.
// A result waits in the output register while the next item is taken; a
// stalled result holds the in-flight item until the output register frees.
// Reset is synchronous; no clearing pass runs, the stores start undefined.
`default_nettype none

module frame_ring_buffer_overwrite_oldest_core
  import frb_pkg::*;
#(
  parameter int SLOTS      = 16,
  parameter int SLOT_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [BYTE_W-1:0]   in_data_byte,
  input  logic                in_last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                out_last,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_frame_count
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int OFF_W  = $clog2(SLOT_BYTES);
  localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
  localparam int HELD_W = $clog2(SLOTS + 1);
  localparam int DEPTH  = SLOTS * SLOT_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(SLOTS - 1);
  localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(SLOT_BYTES);
  localparam logic [HELD_W-1:0] HELD_FULL   = HELD_W'(SLOTS);
  localparam logic [ADDR_W-1:0] SLOT_STRIDE = ADDR_W'(SLOT_BYTES);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  // Ring indices.
  logic [SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [LEN_W-1:0]  wr_off_r,  wr_off_nxt;
  logic [OFF_W-1:0]  rd_off_r,  rd_off_nxt;
  logic [HELD_W-1:0] held_r,    held_nxt;

  // In-flight item.
  logic              s1_valid_r;
  logic [KIND_W-1:0] s1_kind_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic              s1_last_r;

  // Output register.
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_last_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic in_fire;
  logic s1_done;

  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] st_rdata;
  logic [LEN_W-1:0]  len_rdata;

  logic                drop;
  logic                fits;
  logic [LEN_W-1:0]    wr_off_inc;
  logic [LEN_W-1:0]    rd_off_inc;
  logic [LEN_W-1:0]    wr_off_len;
  logic                st_we;
  logic                len_we;
  logic [BYTE_W-1:0]   res_byte;
  logic                res_last;
  logic [STATUS_W-1:0] res_status;

  assign in_ready = !s1_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign s1_done  = s1_valid_r && (!out_valid_r || out_ready);

  assign rd_addr = ADDR_W'(rd_slot_r) * SLOT_STRIDE + ADDR_W'(rd_off_r);
  assign wr_addr = ADDR_W'(wr_slot_r) * SLOT_STRIDE + ADDR_W'(wr_off_r);

  frb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_byte_ram (
    .clk   (clk),
    .we    (s1_done && st_we),
    .waddr (wr_addr),
    .wdata (s1_data_r),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  frb_ram #(
    .WIDTH (LEN_W),
    .DEPTH (SLOTS)
  ) u_len_ram (
    .clk   (clk),
    .we    (s1_done && len_we),
    .waddr (wr_slot_r),
    .wdata (wr_off_len),
    .re    (in_fire),
    .raddr (rd_slot_r),
    .rdata (len_rdata)
  );

  always_comb begin
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    wr_off_nxt  = wr_off_r;
    rd_off_nxt  = rd_off_r;
    held_nxt    = held_r;
    st_we       = 1'b0;
    len_we      = 1'b0;
    res_byte    = '0;
    res_last    = 1'b0;
    res_status  = STATUS_STORED;

    // A new frame into a full ring evicts the head frame first.
    drop       = (wr_off_r == '0) && (held_r == HELD_FULL);
    fits       = wr_off_r < LEN_MAX;
    wr_off_inc = wr_off_r + 1'b1;
    rd_off_inc = LEN_W'(rd_off_r) + 1'b1;
    wr_off_len = fits ? wr_off_inc : wr_off_r;

    unique case (s1_kind_r)
      KIND_PUSH: begin
        if (drop) begin
          rd_slot_nxt = next_slot(rd_slot_r);
          rd_off_nxt  = '0;
          res_status  = STATUS_DROPPED;
        end
        if (fits) begin
          st_we = 1'b1;
        end else begin
          res_status = STATUS_TRUNC;
        end
        held_nxt = held_r - HELD_W'(drop) + HELD_W'(s1_last_r);
        if (s1_last_r) begin
          len_we      = 1'b1;
          wr_slot_nxt = next_slot(wr_slot_r);
          wr_off_nxt  = '0;
        end else begin
          wr_off_nxt = wr_off_len;
        end
      end
      KIND_POP: begin
        if (held_r == '0) begin
          res_status = STATUS_EMPTY;
        end else begin
          res_status = STATUS_POPPED;
          res_byte   = st_rdata;
          if (rd_off_inc >= len_rdata) begin
            res_last    = 1'b1;
            rd_off_nxt  = '0;
            rd_slot_nxt = next_slot(rd_slot_r);
            held_nxt    = held_r - 1'b1;
          end else begin
            rd_off_nxt = rd_off_inc[OFF_W-1:0];
          end
        end
      end
      default: begin
        // Flush; the unused kind code behaves the same way.
        wr_slot_nxt = '0;
        rd_slot_nxt = '0;
        wr_off_nxt  = '0;
        rd_off_nxt  = '0;
        held_nxt    = '0;
        res_status  = STATUS_FLUSHED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wr_slot_r   <= '0;
      rd_slot_r   <= '0;
      wr_off_r    <= '0;
      rd_off_r    <= '0;
      held_r      <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_done) begin
        out_valid_r <= 1'b1;
        wr_slot_r   <= wr_slot_nxt;
        rd_slot_r   <= rd_slot_nxt;
        wr_off_r    <= wr_off_nxt;
        rd_off_r    <= rd_off_nxt;
        held_r      <= held_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= in_kind;
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_done) begin
      out_byte_r   <= res_byte;
      out_last_r   <= res_last;
      out_status_r <= res_status;
      out_count_r  <= COUNT_W'(held_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last        = out_last_r;
  assign out_status      = out_status_r;
  assign out_frame_count = out_count_r;

endmodule

`default_nettype wire

// ===== hw/rtl/frb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module frb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/frb_checker.sv =====
// Port-level checker of the frame ring buffer, bound to the top level.
`default_nettype none

`include "frame_ring_buffer_overwrite_oldest_core_macros.svh"

module frb_checker
  import frb_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [KIND_W-1:0]   in_kind,
  input logic [BYTE_W-1:0]   in_data_byte,
  input logic                in_last_byte,
  input logic                out_valid,
  input logic                out_ready,
  input logic [BYTE_W-1:0]   out_byte,
  input logic                out_last,
  input logic [STATUS_W-1:0] out_status,
  input logic [COUNT_W-1:0]  out_frame_count
);

  // A stalled result keeps its whole payload.
  `FRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_status) && $stable(out_frame_count), "result changed while stalled")

  // Only a pop that returned a byte carries data or an end-of-frame mark.
  `FRB_ASSERT_NOW(a_nonpop_zero, out_valid && (out_status != STATUS_POPPED), (out_byte == '0) && !out_last, "data on a result that is not a pop")

  // A flush leaves no frames behind.
  `FRB_ASSERT_NOW(a_flush_count, out_valid && (out_status == STATUS_FLUSHED), out_frame_count == '0, "frame count not zero after flush")

  // A fresh result follows a matching input transfer.
  `FRB_ASSERT_NOW(a_result_origin, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a matching input transfer")

endmodule

bind frame_ring_buffer_overwrite_oldest_core frb_checker u_frb_checker (.*);

`default_nettype wire

// ===== tb/sv/frb_queue_monitor.sv =====
// Watches both channels of the frame ring buffer, predicts every result and compares it.
`timescale 1ns / 100ps

module frb_queue_monitor
  import frb_pkg::*;
#(
  parameter int SLOTS      = 16,
  parameter int SLOT_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [BYTE_W-1:0]   in_data_byte,
  input  logic                in_last_byte,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [BYTE_W-1:0]   out_byte,
  input  logic                out_last,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [COUNT_W-1:0]  out_frame_count,
  output int                  mismatches,
  output int                  outstanding,
  output int                  compared
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int OFS_W  = $clog2(SLOT_BYTES) + 1;

  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } frame_result_t;

  // Shadow copy of the ring: byte store, frame lengths, indices and count.
  logic [BYTE_W-1:0]  byte_store [SLOTS*SLOT_BYTES];
  logic [OFS_W-1:0]   frame_len [SLOTS];
  logic [SLOT_W-1:0]  wr_slot = '0;
  logic [SLOT_W-1:0]  rd_slot = '0;
  logic [OFS_W-1:0]   wr_ofs = '0;
  logic [OFS_W-1:0]   rd_ofs = '0;
  logic [COUNT_W-1:0] held = '0;

  frame_result_t predicted_results[$];
  int errors = 0;
  int n_compared = 0;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  task automatic apply_frame_item(input logic [KIND_W-1:0] kind,
                                  input logic [BYTE_W-1:0] data,
                                  input logic last_mark,
                                  output frame_result_t res);
    res = '0;
    case (kind)
      KIND_PUSH: begin
        res.status = STATUS_STORED;
        // A new frame on a full ring pushes out the head frame first.
        if (wr_ofs == '0 && held >= SLOTS) begin
          rd_slot    = next_slot(rd_slot);
          rd_ofs     = '0;
          held       = held - 1'b1;
          res.status = STATUS_DROPPED;
        end
        if (wr_ofs < SLOT_BYTES) begin
          byte_store[wr_slot * SLOT_BYTES + wr_ofs] = data;
          wr_ofs = wr_ofs + 1'b1;
        end else begin
          res.status = STATUS_TRUNC;
        end
        if (last_mark) begin
          frame_len[wr_slot] = wr_ofs;
          wr_slot = next_slot(wr_slot);
          wr_ofs  = '0;
          held    = held + 1'b1;
        end
      end
      KIND_POP: begin
        if (held == '0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.status = STATUS_POPPED;
          if (rd_ofs < SLOT_BYTES) begin
            res.data = byte_store[rd_slot * SLOT_BYTES + rd_ofs];
          end
          rd_ofs = rd_ofs + 1'b1;
          if (rd_ofs >= frame_len[rd_slot]) begin
            res.last = 1'b1;
            rd_ofs   = '0;
            rd_slot  = next_slot(rd_slot);
            held     = held - 1'b1;
          end
        end
      end
      default: begin
        // Flush, and the unused kind encoding behaves the same way.
        wr_slot    = '0;
        rd_slot    = '0;
        held       = '0;
        wr_ofs     = '0;
        rd_ofs     = '0;
        res.status = STATUS_FLUSHED;
      end
    endcase
    res.count = held;
  endtask

  task automatic check_field(input string field, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors = errors + 1;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      wr_slot = '0;
      rd_slot = '0;
      wr_ofs  = '0;
      rd_ofs  = '0;
      held    = '0;
      predicted_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t ns: result with nothing expected, actual byte %0d last %0d status %0d count %0d",
                   $time, out_byte, out_last, out_status, out_frame_count);
          errors = errors + 1;
        end else begin
          want = predicted_results.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("out_last", BYTE_W'(want.last), BYTE_W'(out_last));
          check_field("out_status", BYTE_W'(want.status), BYTE_W'(out_status));
          check_field("out_frame_count", BYTE_W'(want.count), BYTE_W'(out_frame_count));
          n_compared = n_compared + 1;
        end
      end
      if (in_valid && in_ready) begin
        apply_frame_item(in_kind, in_data_byte, in_last_byte, want);
        predicted_results.push_back(want);
      end
    end
    mismatches  <= errors;
    outstanding <= predicted_results.size();
    compared    <= n_compared;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Stimulus and verdict for the frame ring buffer core, with the result monitor beside it.
`timescale 1ns / 100ps

module tb_top;
  import frb_pkg::*;

  localparam int SLOTS          = 16;
  localparam int SLOT_BYTES     = 2048;
  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_ITEMS   = 1160;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int CYCLE_LIMIT    = 200000;

  // Unused kind encoding; the block treats it as a flush.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = KIND_POP;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic out_last;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0] out_frame_count;

  int mismatches;
  int outstanding;
  int compared;

  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  int hold_requests = 0;
  int holds_served = 0;
  int push_items = 0;
  int pop_items = 0;
  int flush_items = 0;
  int cycles = 0;

  always #CLK_HALF clk = ~clk;

  frame_ring_buffer_overwrite_oldest_core #(
    .SLOTS(SLOTS),
    .SLOT_BYTES(SLOT_BYTES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .out_last(out_last),
    .out_status(out_status),
    .out_frame_count(out_frame_count)
  );

  frb_queue_monitor #(
    .SLOTS(SLOTS),
    .SLOT_BYTES(SLOT_BYTES)
  ) u_monitor (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .out_last(out_last),
    .out_status(out_status),
    .out_frame_count(out_frame_count),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .compared(compared)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random back-pressure, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = holds_served + 1;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= !(rx_idling && $urandom_range(0, 99) < 11);
      end
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                           input logic last_mark);
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_data_byte <= data;
    in_last_byte <= last_mark;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (kind)
      KIND_PUSH: push_items = push_items + 1;
      KIND_POP:  pop_items = pop_items + 1;
      default:   flush_items = flush_items + 1;
    endcase
    if (tx_idling) begin
      while ($urandom_range(0, 99) < 11) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic send_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(KIND_PUSH, BYTE_W'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic pop_burst(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_item(KIND_POP, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // The sender stops offering first; the monitor's count is registered, so
  // look only from the next edge on.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int n_random;
    int start_items;
    int unsigned pick;
    bit fill_mode;
    bit paused;

    paused = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Basic behavior: empty pops, short frames, flushes with and without a frame in progress.
    send_item(KIND_POP, 8'h00, 1'b0);
    send_item(KIND_PUSH, 8'h00, 1'b1);
    send_item(KIND_PUSH, 8'hFF, 1'b0);
    send_item(KIND_PUSH, 8'hA5, 1'b1);
    pop_burst(4);
    send_item(KIND_PUSH, 8'h5A, 1'b0);
    send_item(KIND_POP, 8'hFF, 1'b1);
    send_item(KIND_PUSH, 8'h3C, 1'b1);
    send_item(KIND_FLUSH, 8'hFF, 1'b1);
    send_item(KIND_POP, 8'h00, 1'b0);
    send_item(KIND_PUSH, 8'h81, 1'b0);
    send_item(KIND_SPARE, 8'h7E, 1'b1);
    send_item(KIND_PUSH, 8'h42, 1'b1);
    pop_burst(2);

    // Fill every slot while the result side holds off, then overwrite the oldest frame.
    hold_requests = hold_requests + 1;
    repeat (SLOTS) send_frame(2);
    send_frame(3);
    pop_burst((SLOTS - 1) * 2 + 3 + 1);

    // Random traffic that alternates between filling and draining the ring.
    start_items = push_items + pop_items + flush_items;
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      fill_mode = ((n_random / 150) % 2) == 0;
      tx_idling = !(n_random >= 500 && n_random < 800);
      rx_idling = tx_idling;
      if (!paused && n_random >= 1000) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(KIND_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else if (pick < 11) begin
        send_item($urandom_range(0, 1) ? KIND_FLUSH : KIND_SPARE,
                  BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < (fill_mode ? 70 : 40)) begin
        send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4));
      end else begin
        pop_burst(fill_mode ? $urandom_range(1, 3) : $urandom_range(1, 12));
      end
      n_random = push_items + pop_items + flush_items - start_items;
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d pushes, %0d pops and %0d flushes, %0d results compared,",
             push_items, pop_items, flush_items, compared);
    $display("including empty pops, flushes in mid-frame and a full ring overwrite.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
